[rtl/mptdb_pkg.sv]
// mptdb_pkg: shared types, register codes and reset constants of the
// multi-pin time debouncer. No dependencies.
`default_nettype none

package mptdb_pkg;

    localparam int PIN_COUNT_DEF  = 32;
    localparam int CLASS_BITS_DEF = 8;

    localparam int TIME_W     = 32;
    localparam int SETTLE_W   = 16;
    localparam int PIN_W      = 5;
    localparam int LEVEL_W    = 8;
    localparam int CLASS_W    = 8;
    localparam int MASK_W     = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd50;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_SETTLE  = 2'd0,
        REG_TRIGGER = 2'd1,
        REG_ANALOG  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ms;
        logic [MASK_W-1:0]   trigger_levels;
        logic [MASK_W-1:0]   analog_pins;
    } cfg_t;

    // one memory word per pin
    typedef struct packed {
        logic [TIME_W-1:0]  last_change_ms;
        logic [CLASS_W-1:0] stable_class;
        logic [CLASS_W-1:0] candidate_class;
        logic               stable_digital;
        logic               fired;
    } pin_entry_t;

    localparam pin_entry_t ENTRY_RESET = '{
        last_change_ms:  '0,
        stable_class:    '0,
        candidate_class: '0,
        stable_digital:  1'b1,
        fired:           1'b0
    };

endpackage

`default_nettype wire

[rtl/mptdb_cfg_regs.sv]
// mptdb_cfg_regs: APB register bank (settle time, trigger levels, analog mode).
// Depends on mptdb_pkg.
`default_nettype none

module mptdb_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mptdb_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mptdb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mptdb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready,
    output mptdb_pkg::cfg_t                        cfg
);
    import mptdb_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    cfg_reg_t reg_sel;
    logic     wr_en;

    assign reg_sel = cfg_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_SETTLE:  cfg_next.settle_ms      = pwdata[SETTLE_W-1:0];
                REG_TRIGGER: cfg_next.trigger_levels = pwdata[MASK_W-1:0];
                REG_ANALOG:  cfg_next.analog_pins    = pwdata[MASK_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SETTLE:  prdata = APB_DATA_W'(cfg_reg.settle_ms);
            REG_TRIGGER: prdata = APB_DATA_W'(cfg_reg.trigger_levels);
            REG_ANALOG:  prdata = APB_DATA_W'(cfg_reg.analog_pins);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ms      <= SETTLE_RESET;
            cfg_reg.trigger_levels <= '0;
            cfg_reg.analog_pins    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mptdb_pin_mem.sv]
// mptdb_pin_mem: per-pin state memory, registered read, with
// valid bits so that unwritten entries read as their reset value.
// Depends on mptdb_pkg.
`default_nettype none

module mptdb_pin_mem #(
    parameter int PIN_COUNT = mptdb_pkg::PIN_COUNT_DEF,
    parameter int ADDR_W    = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output mptdb_pkg::pin_entry_t      rd_data,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire mptdb_pkg::pin_entry_t wr_data
);
    import mptdb_pkg::*;

    pin_entry_t           mem [PIN_COUNT];
    pin_entry_t           rd_raw_reg;
    logic                 rd_valid_reg;
    logic [PIN_COUNT-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // entries never written show their reset value
    assign rd_data = rd_valid_reg ? rd_raw_reg : ENTRY_RESET;

endmodule

`default_nettype wire

[rtl/mptdb_update.sv]
// mptdb_update: next-state logic of one pin entry for a sample or take request,
// plus the reported pin state and fired flag. Depends on mptdb_pkg.
`default_nettype none

module mptdb_update #(
    parameter int CLASS_BITS = mptdb_pkg::CLASS_BITS_DEF
) (
    input  wire mptdb_pkg::pin_entry_t             entry,
    input  wire mptdb_pkg::cfg_t                   cfg,
    input  wire logic                              kind,
    input  wire logic [mptdb_pkg::PIN_W-1:0]       pin,
    input  wire logic [mptdb_pkg::LEVEL_W-1:0]     level,
    input  wire logic [mptdb_pkg::TIME_W-1:0]      now_ms,
    output mptdb_pkg::pin_entry_t                  entry_next,
    output logic      [mptdb_pkg::CLASS_W-1:0]     pin_state,
    output logic                                   fired
);
    import mptdb_pkg::*;

    localparam int CW = (CLASS_BITS < CLASS_W) ? CLASS_BITS : CLASS_W;

    logic [CLASS_W:0]   mask_wide;
    logic [CLASS_W-1:0] class_mask;
    logic [CLASS_W-1:0] cls;
    logic [TIME_W-1:0]  elapsed;
    logic               expired;
    logic               is_analog;
    logic               trig;

    assign mask_wide  = (CLASS_W+1)'((CLASS_W+1)'(1) << CW) - (CLASS_W+1)'(1);
    assign class_mask = mask_wide[CLASS_W-1:0];
    assign cls        = level[CLASS_W-1:0] & class_mask;
    assign elapsed    = now_ms - entry.last_change_ms;
    assign expired    = elapsed > TIME_W'(cfg.settle_ms);
    assign is_analog  = cfg.analog_pins[pin];
    assign trig       = cfg.trigger_levels[pin];

    always_comb
    begin
        entry_next = entry;
        if (kind)
        begin
            entry_next.fired = 1'b0;
        end
        else if (is_analog)
        begin
            if (cls == entry.stable_class)
            begin
                entry_next.last_change_ms = now_ms;
            end
            else if (cls == entry.candidate_class)
            begin
                if (expired)
                begin
                    entry_next.fired          = 1'b1;
                    entry_next.stable_class   = cls;
                    entry_next.last_change_ms = now_ms;
                end
            end
            else
            begin
                entry_next.candidate_class = cls;
                entry_next.last_change_ms  = now_ms;
            end
        end
        else
        begin
            if (level[0] == entry.stable_digital)
            begin
                entry_next.last_change_ms = now_ms;
            end
            else if (expired)
            begin
                if (level[0] == trig)
                begin
                    entry_next.fired = 1'b1;
                end
                entry_next.stable_digital = level[0];
                entry_next.last_change_ms = now_ms;
            end
        end
    end

    assign pin_state = is_analog ? entry_next.stable_class
                                 : CLASS_W'(entry_next.stable_digital == trig);
    assign fired     = kind ? entry.fired : entry_next.fired;

endmodule

`default_nettype wire

[rtl/multi_pin_time_debouncer.sv]
// multi_pin_time_debouncer: top level, stream in/out, APB configuration.
// Depends on mptdb_pkg, mptdb_cfg_regs, mptdb_pin_mem, mptdb_update.
`default_nettype none

// Time-stamp debouncer for up to PIN_COUNT pins. Each request either samples a
// pin (kind 0) with a level and the current millisecond time, or takes and
// clears the pin's fired flag (kind 1); every request yields exactly one result
// with the pin state and the fired flag. Per-pin state sits in one synchronous
// memory. A request reads the pin's entry; the update stage then updates it,
// writes it back and loads the output register once that is free or emptied.
// The next request is taken in the cycle after the write-back, so a follow-up
// on the same pin always reads fresh data. While a result waits at the output
// one more request can be taken and held in the update stage. After reset
// every pin reads as its reset state at once (valid bits, no clearing pass).
// User must write configuration only while the block is idle (not enforced).

module multi_pin_time_debouncer #(
    parameter int PIN_COUNT  = mptdb_pkg::PIN_COUNT_DEF,
    parameter int CLASS_BITS = mptdb_pkg::CLASS_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tdata, lowest bit up: pin[4:0], level[12:5], now_ms[44:13], zero fill
    input  wire logic [47:0]                       s_tdata,
    // tuser: kind (0 sample, 1 take fired flag)
    input  wire logic                              s_tuser,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tdata, lowest bit up: pin_state[7:0], fired[8], zero fill
    output logic      [15:0]                       m_tdata,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mptdb_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mptdb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [mptdb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);
    import mptdb_pkg::*;

    localparam int ADDR_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    cfg_t cfg;

    // unpacked request fields
    logic [PIN_W-1:0]   in_pin;
    logic [LEVEL_W-1:0] in_level;
    logic [TIME_W-1:0]  in_now;

    // update stage: holds the request while its entry is read and updated
    logic               busy_reg;
    logic               busy_next;
    logic               kind_reg;
    logic [PIN_W-1:0]   pin_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]  now_reg;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CLASS_W-1:0] out_state_reg;
    logic               out_fired_reg;

    logic               accept;
    logic               commit;
    logic               in_range;

    pin_entry_t         rd_entry;
    pin_entry_t         upd_entry;
    logic [CLASS_W-1:0] upd_state;
    logic               upd_fired;

    assign in_pin   = s_tdata[4:0];
    assign in_level = s_tdata[12:5];
    assign in_now   = s_tdata[44:13];

    // one request in flight at a time: the interlock against read-before-write
    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    // update completes once the output register is free or being emptied
    assign commit   = busy_reg && (!out_valid_reg || m_tready);
    assign in_range = int'(pin_reg) < PIN_COUNT;

    mptdb_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mptdb_pin_mem #(
        .PIN_COUNT (PIN_COUNT),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(in_pin)),
        .rd_data (rd_entry),
        .wr_en   (commit && in_range),
        .wr_addr (ADDR_W'(pin_reg)),
        .wr_data (upd_entry)
    );

    mptdb_update #(
        .CLASS_BITS (CLASS_BITS)
    ) u_upd (
        .entry      (rd_entry),
        .cfg        (cfg),
        .kind       (kind_reg),
        .pin        (pin_reg),
        .level      (level_reg),
        .now_ms     (now_reg),
        .entry_next (upd_entry),
        .pin_state  (upd_state),
        .fired      (upd_fired)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (commit)
        begin
            busy_next = 1'b0;
        end
        else if (accept)
        begin
            busy_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= s_tuser;
            pin_reg   <= in_pin;
            level_reg <= in_level;
            now_reg   <= in_now;
        end
        if (commit)
        begin
            // pins beyond the table report zero and change nothing
            out_state_reg <= in_range ? upd_state : '0;
            out_fired_reg <= in_range && upd_fired;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_fired_reg, out_state_reg};

endmodule

`default_nettype wire

[rtl/mptdb_checker.sv]
// mptdb_checker: port-level assertions for the debouncer, bound to the top level.
// Depends on multi_pin_time_debouncer port names only.
`default_nettype none

module mptdb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        pready
);

    // a request blocks the input for the cycle of its memory update
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready in the cycle after a request");

    // a fresh result always follows a taken request, with the memory read and the update between them
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding request");

    // result stays offered while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    // fill bits of the result word and the always-ready configuration port
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:9] == 7'b0 && pready))
        else $error("result fill bits set or configuration port stalled");

endmodule

bind multi_pin_time_debouncer mptdb_checker u_mptdb_checker (.*);

`default_nettype wire
